// File: sv/jrma_pkg.sv
`default_nettype none

package jrma_pkg;

    localparam int MAX_WINDOW_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int WIN_W     = 6;
    localparam int THR_W     = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 24;

    localparam logic [WIN_W-1:0] WINDOW_RESET    = WIN_W'(20);
    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(150);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW    = 1'b0,
        REG_THRESHOLD = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

// File: sv/jump_reset_moving_average.sv
// Moving average over the last window_length samples with a restart on a large step. Each
// request carries one signed sample and returns one result: the average truncated toward
// zero, or the raw sample with the restarted flag set when the step from the previously
// stored sample exceeds jump_threshold or the running sum is zero. A normal sample goes
// through the bit-serial divider; a restart refills the sample memory one entry per cycle
// for the window length, clamped to 1 through MAX_WINDOW. The first sample after reset
// always restarts. Items are processed one at a time, and the next request is taken
// while the previous result waits for the sink.
`default_nettype none

module jump_reset_moving_average #(
    parameter int MAX_WINDOW  = jrma_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = jrma_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [jrma_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [jrma_pkg::CFG_W-1:0]            cfg_data,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // Fields from bit 0: sample.
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // Fields from bit 0: filtered.
    output logic      [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,
    // Fields from bit 0: restarted.
    output logic                                       m_tuser
);

    localparam int IDX_W  = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + IDX_W;
    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CMP_W  = (SAMPLE_BITS + 1 > jrma_pkg::THR_W) ?
                            SAMPLE_BITS + 1 : jrma_pkg::THR_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_FILL,
        S_OLD,
        S_DIV,
        S_OUT
    } state_t;

    state_t                      state_reg;
    logic [jrma_pkg::WIN_W-1:0]  window_reg;
    logic [jrma_pkg::THR_W-1:0]  threshold_reg;
    logic [SAMPLE_BITS-1:0]      sample_reg;
    logic [IDX_W-1:0]            write_index_reg;
    logic [IDX_W-1:0]            fill_idx_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic [SAMPLE_BITS-1:0]      res_reg;
    logic                        res_restart_reg;
    logic                        out_valid_reg;
    logic [SAMPLE_BITS-1:0]      filtered_reg;
    logic                        restarted_reg;

    logic [LEN_W-1:0]            len;
    logic [LEN_W-1:0]            len_last;
    logic [IDX_W-1:0]            idx_next;
    logic [SAMPLE_BITS-1:0]      ring_rdata;
    logic                        ring_we;
    logic [IDX_W-1:0]            ring_waddr;
    logic [IDX_W-1:0]            ring_raddr;
    logic [SAMPLE_BITS:0]        diff;
    logic [SAMPLE_BITS:0]        diff_abs;
    logic                        restart;
    logic [SUM_W-1:0]            sample_ext;
    logic [SUM_W-1:0]            old_ext;
    logic [SUM_W-1:0]            sum_next;
    logic                        div_start;
    logic                        div_done;
    logic [SUM_W-1:0]            div_quot;
    logic                        out_free;

    always_comb
    begin
        if (window_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (int'(window_reg) > MAX_WINDOW)
        begin
            len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            len = LEN_W'(window_reg);
        end
        len_last = len - 1'b1;
        idx_next = (LEN_W'(write_index_reg) >= len_last) ? '0 : write_index_reg + 1'b1;

        diff     = {sample_reg[SAMPLE_BITS-1], sample_reg}
                 - {ring_rdata[SAMPLE_BITS-1], ring_rdata};
        diff_abs = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;
        restart  = (CMP_W'(diff_abs) > CMP_W'(threshold_reg)) || (sum_reg == '0);

        sample_ext = {{IDX_W{sample_reg[SAMPLE_BITS-1]}}, sample_reg};
        old_ext    = {{IDX_W{ring_rdata[SAMPLE_BITS-1]}}, ring_rdata};
        sum_next   = sum_reg - old_ext + sample_ext;

        ring_we    = (state_reg == S_FILL) || (state_reg == S_OLD);
        ring_waddr = (state_reg == S_FILL) ? fill_idx_reg : write_index_reg;
        ring_raddr = (state_reg == S_LOOK) ? idx_next : write_index_reg;
        div_start  = (state_reg == S_OLD);
        out_free   = !out_valid_reg || m_tready;
    end

    jrma_ring #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SAMPLE_BITS)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (sample_reg),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    jrma_div #(
        .NUM_W (SUM_W),
        .DEN_W (LEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (len),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= jrma_pkg::WINDOW_RESET;
            threshold_reg <= jrma_pkg::THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (jrma_pkg::cfg_reg_t'(cfg_index))
                jrma_pkg::REG_WINDOW:    window_reg    <= cfg_data[jrma_pkg::WIN_W-1:0];
                jrma_pkg::REG_THRESHOLD: threshold_reg <= cfg_data[jrma_pkg::THR_W-1:0];
                default:                 window_reg    <= window_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            write_index_reg <= '0;
            fill_idx_reg    <= '0;
            sum_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        sample_reg <= s_tdata[SAMPLE_BITS-1:0];
                        state_reg  <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    if (restart)
                    begin
                        write_index_reg <= '0;
                        fill_idx_reg    <= '0;
                        sum_reg         <= '0;
                        state_reg       <= S_FILL;
                    end
                    else
                    begin
                        write_index_reg <= idx_next;
                        state_reg       <= S_OLD;
                    end
                end
                S_FILL:
                begin
                    sum_reg      <= sum_reg + sample_ext;
                    fill_idx_reg <= fill_idx_reg + 1'b1;
                    if (LEN_W'(fill_idx_reg) == len_last)
                    begin
                        res_reg         <= sample_reg;
                        res_restart_reg <= 1'b1;
                        state_reg       <= S_OUT;
                    end
                end
                S_OLD:
                begin
                    sum_reg   <= sum_next;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        res_reg         <= div_quot[SAMPLE_BITS-1:0];
                        res_restart_reg <= 1'b0;
                        state_reg       <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        filtered_reg  <= res_reg;
                        restarted_reg <= res_restart_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'(filtered_reg);
    assign m_tuser  = restarted_reg;

endmodule

`default_nettype wire

// File: sv/jrma_ring.sv
`default_nettype none

module jrma_ring #(
    parameter int DEPTH = jrma_pkg::MAX_WINDOW_DEF,
    parameter int WIDTH = jrma_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/jrma_div.sv
`default_nettype none

module jrma_div #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 6
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic      [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] dq_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W-1:0] rem_next;

    // One quotient bit per cycle on the dividend's magnitude.
    always_comb
    begin
        trial    = {rem_reg, dq_reg[NUM_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                neg_reg  <= dividend[NUM_W-1];
                dq_reg   <= dividend[NUM_W-1] ? (~dividend + 1'b1) : dividend;
                rem_reg  <= '0;
                den_reg  <= divisor;
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                dq_reg  <= {dq_reg[NUM_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~dq_reg + 1'b1) : dq_reg;

endmodule

`default_nettype wire
